>>> rtl/ir_pulse_train_learner_unit_assert.svh
// ----------------------------------------------------------------------------
// ir pulse train learner assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_TRAIN_LEARNER_UNIT_ASSERT_SVH
`define IR_PULSE_TRAIN_LEARNER_UNIT_ASSERT_SVH

// same-cycle implication
`define IPL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IPL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/ipl_pkg.sv
// ----------------------------------------------------------------------------
// ipl_pkg
// types and constants shared by the ir pulse train learner
// ----------------------------------------------------------------------------
`default_nettype none

package ipl_pkg;

    localparam int BUFFER_ENTRIES = 2048;
    localparam int CAL_PERIODS    = 16;
    localparam int CAL_SHIFT      = $clog2(CAL_PERIODS);
    localparam int CAL_CNT_W      = $clog2(CAL_PERIODS + 1);

    localparam int TIME_W   = 32;
    localparam int SUM_W    = TIME_W + CAL_SHIFT;
    localparam int LIMIT_W  = 16;
    localparam int ENTRY_W  = 12;
    localparam int KIND_W   = 3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

    localparam logic OP_START = 1'b0;
    localparam logic OP_EDGE  = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_START_OK  = 3'd0,
        KIND_START_REJ = 3'd1,
        KIND_PERIOD    = 3'd2,
        KIND_BURST     = 3'd3,
        KIND_GAP       = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        PH_FIRST   = 2'd0,
        PH_CALIB   = 2'd1,
        PH_COLLECT = 2'd2,
        PH_DONE    = 2'd3
    } phase_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TIME_W-1:0]  value;
        logic [ENTRY_W-1:0] entry_index;
        logic               last;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    typedef struct packed {
        logic [FIFO_LVL_W-1:0] level;
        logic                  room_two;
    } fifo_status_t;

endpackage

`default_nettype wire

>>> rtl/ipl_out_fifo.sv
// ----------------------------------------------------------------------------
// ipl_out_fifo
// result queue taking up to two results a cycle and giving one
// ----------------------------------------------------------------------------
`default_nettype none

module ipl_out_fifo (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ipl_pkg::push_t        push,
    input  wire logic                  pop,
    output ipl_pkg::result_t           head,
    output ipl_pkg::fifo_status_t      status
);
    import ipl_pkg::*;

    result_t                mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_LVL_W-1:0]  level_reg, level_next;
    logic                   do_pop;
    logic [FIFO_PTR_W-1:0]  wr_ptr_plus1;

    assign do_pop       = pop && (level_reg != '0);
    assign wr_ptr_plus1 = wr_ptr_reg + FIFO_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(do_pop);
        level_next  = level_reg + FIFO_LVL_W'(push.count) - FIFO_LVL_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.r0;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_plus1] <= push.r1;
    end

    assign head            = mem_reg[rd_ptr_reg];
    assign status.level    = level_reg;
    assign status.room_two = (level_reg <= FIFO_LVL_W'(FIFO_DEPTH - 2));

endmodule

`default_nettype wire

>>> rtl/ipl_core.sv
// ----------------------------------------------------------------------------
// ipl_core
// input register, run state and per-edge result logic
// ----------------------------------------------------------------------------
`default_nettype none

module ipl_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          op,
    input  wire logic [ipl_pkg::TIME_W-1:0]    edge_time,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ipl_pkg::LIMIT_W-1:0]   cfg_wr_data,
    input  wire ipl_pkg::fifo_status_t         fifo_status,
    output ipl_pkg::push_t                     push
);
    import ipl_pkg::*;

    // input register
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_op_reg;
    logic [TIME_W-1:0]  s1_time_reg;

    // run state
    logic [LIMIT_W-1:0]   sample_limit_reg;
    logic [ENTRY_W-1:0]   run_limit_reg, run_limit_next;
    phase_t               phase_reg, phase_next;
    logic [TIME_W-1:0]    prev_time_reg, prev_time_next;
    logic [SUM_W-1:0]     period_sum_reg, period_sum_next;
    logic [CAL_CNT_W-1:0] cal_count_reg, cal_count_next;
    logic [TIME_W-1:0]    carrier_reg, carrier_next;
    logic [ENTRY_W-1:0]   entry_cnt_reg, entry_cnt_next;
    logic [TIME_W-1:0]    burst_cnt_reg, burst_cnt_next;
    logic                 first_burst_reg, first_burst_next;

    logic                 accept;
    logic                 advance;
    logic                 reject;
    logic [TIME_W-1:0]    period;
    logic [SUM_W-1:0]     sum_add;
    logic [CAL_CNT_W-1:0] cal_count_inc;
    logic                 cal_done;
    logic [TIME_W-1:0]    carrier_new;
    logic                 burst_end;
    logic [TIME_W-1:0]    burst_value;
    logic [TIME_W-1:0]    gap;
    logic [ENTRY_W-1:0]   entry_after;
    logic                 calib_last;
    logic                 collect_last;

    assign advance  = s1_valid_reg && fifo_status.room_two;
    assign in_stall = s1_valid_reg && !fifo_status.room_two;
    assign accept   = in_valid && !in_stall;

    assign reject        = ({1'b0, sample_limit_reg} + (LIMIT_W+1)'(2))
                           > (LIMIT_W+1)'(BUFFER_ENTRIES);
    assign period        = s1_time_reg - prev_time_reg;
    assign sum_add       = period_sum_reg + SUM_W'(period);
    assign cal_count_inc = cal_count_reg + CAL_CNT_W'(1);
    assign cal_done      = (cal_count_inc == CAL_CNT_W'(CAL_PERIODS));
    assign carrier_new   = sum_add[CAL_SHIFT +: TIME_W];
    // threshold at 33 bits so twice the carrier never wraps
    assign burst_end     = {1'b0, period} > {carrier_reg, 1'b0};
    assign burst_value   = burst_cnt_reg + (first_burst_reg ? TIME_W'(CAL_PERIODS) : '0);
    assign gap           = period - {1'b0, carrier_reg[TIME_W-1:1]};
    assign entry_after   = entry_cnt_reg + ENTRY_W'(2);
    assign calib_last    = (entry_cnt_reg >= run_limit_reg);
    assign collect_last  = (entry_after >= run_limit_reg);

    always_comb
    begin
        s1_valid_next = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    end

    // next state
    always_comb
    begin
        run_limit_next   = run_limit_reg;
        phase_next       = phase_reg;
        prev_time_next   = prev_time_reg;
        period_sum_next  = period_sum_reg;
        cal_count_next   = cal_count_reg;
        carrier_next     = carrier_reg;
        entry_cnt_next   = entry_cnt_reg;
        burst_cnt_next   = burst_cnt_reg;
        first_burst_next = first_burst_reg;
        if (advance)
        begin
            if (s1_op_reg == OP_START)
            begin
                if (!reject)
                begin
                    run_limit_next   = sample_limit_reg[ENTRY_W-1:0];
                    phase_next       = PH_FIRST;
                    prev_time_next   = '0;
                    period_sum_next  = '0;
                    cal_count_next   = '0;
                    carrier_next     = '0;
                    entry_cnt_next   = '0;
                    burst_cnt_next   = '0;
                    first_burst_next = 1'b1;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_FIRST:
                    begin
                        prev_time_next = s1_time_reg;
                        phase_next     = PH_CALIB;
                    end
                    PH_CALIB:
                    begin
                        prev_time_next  = s1_time_reg;
                        period_sum_next = sum_add;
                        cal_count_next  = cal_count_inc;
                        if (cal_done)
                        begin
                            carrier_next = carrier_new;
                            phase_next   = calib_last ? PH_DONE : PH_COLLECT;
                        end
                    end
                    PH_COLLECT:
                    begin
                        prev_time_next = s1_time_reg;
                        if (!burst_end)
                            burst_cnt_next = burst_cnt_reg + TIME_W'(1);
                        else
                        begin
                            entry_cnt_next   = entry_after;
                            burst_cnt_next   = '0;
                            first_burst_next = 1'b0;
                            if (collect_last)
                                phase_next = PH_DONE;
                        end
                    end
                    PH_DONE:
                    begin
                        phase_next = PH_DONE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // results
    always_comb
    begin
        push.count = 2'd0;
        push.r0    = '0;
        push.r1    = '0;
        if (advance)
        begin
            if (s1_op_reg == OP_START)
            begin
                push.count   = 2'd1;
                push.r0.kind = reject ? KIND_START_REJ : KIND_START_OK;
            end
            else
            begin
                unique case (phase_reg) inside
                    PH_CALIB:
                    begin
                        if (cal_done)
                        begin
                            push.count   = 2'd1;
                            push.r0.kind = KIND_PERIOD;
                            push.r0.value = carrier_new;
                            push.r0.last = calib_last;
                        end
                    end
                    PH_COLLECT:
                    begin
                        if (burst_end)
                        begin
                            push.count          = 2'd2;
                            push.r0.kind        = KIND_BURST;
                            push.r0.value       = burst_value;
                            push.r0.entry_index = entry_cnt_reg;
                            push.r1.kind        = KIND_GAP;
                            push.r1.value       = gap;
                            push.r1.entry_index = entry_cnt_reg + ENTRY_W'(1);
                            push.r1.last        = collect_last;
                        end
                    end
                    PH_FIRST, PH_DONE:
                    begin
                        push.count = 2'd0;
                    end
                    default:
                    begin
                        push.count = 2'd0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            sample_limit_reg <= '0;
            run_limit_reg    <= '0;
            phase_reg        <= PH_FIRST;
            prev_time_reg    <= '0;
            period_sum_reg   <= '0;
            cal_count_reg    <= '0;
            carrier_reg      <= '0;
            entry_cnt_reg    <= '0;
            burst_cnt_reg    <= '0;
            first_burst_reg  <= 1'b1;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (cfg_wr_en)
                sample_limit_reg <= cfg_wr_data;
            run_limit_reg   <= run_limit_next;
            phase_reg       <= phase_next;
            prev_time_reg   <= prev_time_next;
            period_sum_reg  <= period_sum_next;
            cal_count_reg   <= cal_count_next;
            carrier_reg     <= carrier_next;
            entry_cnt_reg   <= entry_cnt_next;
            burst_cnt_reg   <= burst_cnt_next;
            first_burst_reg <= first_burst_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= op;
            s1_time_reg <= edge_time;
        end
    end

endmodule

`default_nettype wire

>>> rtl/ir_pulse_train_learner_unit.sv
// ----------------------------------------------------------------------------
// ir_pulse_train_learner_unit
// learns carrier period, burst counts and gaps from carrier edge timestamps
// ----------------------------------------------------------------------------
// path: a request waits in the input register until the queue has room for two
//   results, then its results are queued and offered; a burst end queues two results
// throughput: one request per cycle while the queue has that room; the
//   one-result-per-cycle output side with a four-entry queue sets the long-run pace
// reset: asynchronous active-low, clears run state, sample limit and queue
`default_nettype none

`include "ir_pulse_train_learner_unit_assert.svh"

module ir_pulse_train_learner_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          op,
    input  wire logic [ipl_pkg::TIME_W-1:0]    edge_time,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [ipl_pkg::KIND_W-1:0]         kind,
    output logic [ipl_pkg::TIME_W-1:0]         value,
    output logic [ipl_pkg::ENTRY_W-1:0]        entry_index,
    output logic                               last,
    input  wire logic                          cfg_wr_en,
    input  wire logic [ipl_pkg::LIMIT_W-1:0]   cfg_wr_data
);
    import ipl_pkg::*;

    push_t        push;
    fifo_status_t fifo_status;
    result_t      head;

    ipl_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .edge_time   (edge_time),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fifo_status (fifo_status),
        .push        (push)
    );

    ipl_out_fifo u_out_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .pop    (!out_stall),
        .head   (head),
        .status (fifo_status)
    );

    assign out_valid   = (fifo_status.level != '0);
    assign kind        = head.kind;
    assign value       = head.value;
    assign entry_index = head.entry_index;
    assign last        = head.last;

    `IPL_ASSERT_NOW(a_queue_bound, 1'b1, fifo_status.level <= FIFO_LVL_W'(FIFO_DEPTH), "result queue overfilled")
    `IPL_ASSERT_NOW(a_gap_odd, out_valid && (kind == KIND_GAP), entry_index[0], "gap entry at even index")
    `IPL_ASSERT_NOW(a_burst_even, out_valid && (kind == KIND_BURST), !entry_index[0] && !last, "burst entry misplaced")
    `IPL_ASSERT_NOW(a_start_clean, out_valid && ((kind == KIND_START_OK) || (kind == KIND_START_REJ)), (value == '0) && (entry_index == '0) && !last, "start result not clean")

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: ir pulse train learner bench
// Runs a short table of starts, limit writes and edge runs, then random
// learning sessions. An in-order tracker of the learner follows every
// accepted request, and each result is compared field by field as it leaves.
// ---------------------------------------------------------------------------
module tb_top;
    import ipl_pkg::*;

    localparam int   CLK_HALF      = 4;
    localparam int   RESET_CYCLES  = 11;
    localparam int   SETTLE_CYCLES = 8;
    localparam int   RANDOM_ITEMS  = 2000;
    localparam int   HOLD_CYCLES   = 300;
    localparam int   MAX_REPORTS   = 10;
    localparam int   DIR_ROWS      = 24;
    localparam logic ROW_CFG       = 1'b1;
    localparam logic ROW_REQ       = 1'b0;

    typedef struct packed {
        logic               row_kind;
        logic [LIMIT_W-1:0] limit;
        logic               op;
        logic [TIME_W-1:0]  t0;
        logic [TIME_W-1:0]  step;
        logic [7:0]         reps;
        logic               typed;
        kind_t              typed_kind;
    } dir_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                op;
    logic [TIME_W-1:0]   edge_time;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [KIND_W-1:0]   kind;
    logic [TIME_W-1:0]   value;
    logic [ENTRY_W-1:0]  entry_index;
    logic                last;
    logic                cfg_wr_en;
    logic [LIMIT_W-1:0]  cfg_wr_data;

    // tracker of the learner
    logic [LIMIT_W-1:0]  lim_cfg;
    logic [LIMIT_W-1:0]  lim_run;
    phase_t              trk_phase;
    logic [TIME_W-1:0]   trk_prev;
    logic [SUM_W-1:0]    trk_sum;
    int                  trk_cal;
    logic [TIME_W-1:0]   trk_carrier;
    logic [15:0]         trk_entry;
    logic [TIME_W-1:0]   trk_bursts;
    logic                trk_first;

    result_t             learned_q [$];
    dir_row_t            dir_tab [DIR_ROWS];
    int                  bad = 0;
    int                  items_sent = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  hold_req = 0;
    int                  hold_seen = 0;
    int                  hold_left = 0;

    ir_pulse_train_learner_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .edge_time   (edge_time),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .value       (value),
        .entry_index (entry_index),
        .last        (last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("[ir_pulse_train_learner_unit] ERROR");
        $finish;
    end

    task automatic clear_tracker();
        trk_phase   = PH_FIRST;
        trk_prev    = '0;
        trk_sum     = '0;
        trk_cal     = 0;
        trk_carrier = '0;
        trk_entry   = '0;
        trk_bursts  = '0;
        trk_first   = 1'b1;
    endtask

    task automatic advance_learner(input logic req_op, input logic [TIME_W-1:0] t,
                                   input bit keep);
        result_t           r;
        logic [TIME_W-1:0] period;
        begin
            r = '0;
            if (req_op == OP_START)
            begin
                if (32'(lim_cfg) + 32'd2 > BUFFER_ENTRIES)
                    r.kind = KIND_START_REJ;
                else
                begin
                    lim_run = lim_cfg;
                    clear_tracker();
                    r.kind = KIND_START_OK;
                end
                if (keep)
                    learned_q.push_back(r);
                return;
            end
            period = t - trk_prev;
            case (trk_phase)
                PH_FIRST:
                begin
                    trk_prev  = t;
                    trk_phase = PH_CALIB;
                end
                PH_CALIB:
                begin
                    trk_prev = t;
                    trk_sum  = trk_sum + SUM_W'(period);
                    trk_cal++;
                    if (trk_cal >= CAL_PERIODS)
                    begin
                        trk_carrier = TIME_W'(trk_sum >> CAL_SHIFT);
                        r.kind      = KIND_PERIOD;
                        r.value     = trk_carrier;
                        r.last      = (trk_entry >= lim_run);
                        trk_phase   = r.last ? PH_DONE : PH_COLLECT;
                        if (keep)
                            learned_q.push_back(r);
                    end
                end
                PH_COLLECT:
                begin
                    trk_prev = t;
                    // threshold is twice the carrier at full width, no wrap
                    if ({1'b0, period} <= {trk_carrier, 1'b0})
                        trk_bursts = trk_bursts + 1'b1;
                    else
                    begin
                        r.kind        = KIND_BURST;
                        r.value       = trk_bursts + (trk_first ? TIME_W'(CAL_PERIODS) : '0);
                        r.entry_index = ENTRY_W'(trk_entry);
                        if (keep)
                            learned_q.push_back(r);
                        r.kind        = KIND_GAP;
                        r.value       = period - (trk_carrier >> 1);
                        r.entry_index = ENTRY_W'(trk_entry + 16'd1);
                        trk_entry     = trk_entry + 16'd2;
                        trk_bursts    = '0;
                        trk_first     = 1'b0;
                        if (trk_entry >= lim_run)
                        begin
                            trk_phase = PH_DONE;
                            r.last    = 1'b1;
                        end
                        if (keep)
                            learned_q.push_back(r);
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic send_req(input logic req_op, input logic [TIME_W-1:0] t, input bit keep);
        int gap;
        begin
            gap = 0;
            while (gap < 20 && $urandom_range(0, 99) < send_idle_pct)
                gap++;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid  <= 1'b1;
            op        <= req_op;
            edge_time <= t;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            advance_learner(req_op, t, keep);
            items_sent++;
        end
    endtask

    // limit writes only once the learner has drained
    task automatic write_limit(input logic [LIMIT_W-1:0] lim);
        in_valid <= 1'b0;
        while (learned_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= lim;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        lim_cfg = lim;
    endtask

    task automatic set_idle_mode(input int m);
        case (m)
            0:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 66;
                recv_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 66;
            end
            default:
            begin
                send_idle_pct  = 28;
                recv_stall_pct = 28;
            end
        endcase
    endtask

    function automatic logic [TIME_W-1:0] jitter_period(input logic [TIME_W-1:0] p,
                                                        input logic [TIME_W-1:0] j);
        return p - j + TIME_W'($urandom_range(0, 2 * j));
    endfunction

    // one learning run: optional limit write, start, calibration, bursts and gaps
    task automatic learn_session(input int stop_at);
        logic [TIME_W-1:0]  t;
        logic [TIME_W-1:0]  p;
        logic [TIME_W-1:0]  j;
        logic [63:0]        wide;
        logic [LIMIT_W-1:0] new_lim;
        logic               noise_op;
        int                 n_bursts;
        int                 n_edges;
        begin
            if ($urandom_range(0, 9) < 4)
            begin
                case ($urandom_range(0, 19)) inside
                    0:       new_lim = LIMIT_W'($urandom_range(2047, 65535));
                    1:       new_lim = LIMIT_W'($urandom_range(200, 2046));
                    2, 3, 4: new_lim = LIMIT_W'($urandom_range(13, 199));
                    default: new_lim = LIMIT_W'($urandom_range(0, 12));
                endcase
                write_limit(new_lim);
            end
            send_req(OP_START, $urandom, 1'b1);
            case ($urandom_range(0, 9))
                0:       p = $urandom_range(0, 3);
                1:       p = $urandom;
                2:       p = $urandom_range(3000, 1 << 20);
                default: p = $urandom_range(8, 3000);
            endcase
            j = p >> 3;
            t = $urandom;
            send_req(OP_EDGE, t, 1'b1);
            for (int i = 0; i < CAL_PERIODS; i++)
            begin
                t = t + jitter_period(p, j);
                send_req(OP_EDGE, t, 1'b1);
            end
            n_bursts = $urandom_range(1, 40);
            for (int b = 0; b < n_bursts && trk_phase == PH_COLLECT && items_sent < stop_at; b++)
            begin
                n_edges = $urandom_range(0, 12);
                for (int e = 0; e < n_edges; e++)
                begin
                    if ($urandom_range(0, 19) == 0)
                    begin
                        // stray request: random edge or a start in mid-run
                        noise_op = ($urandom_range(0, 3) == 0) ? OP_START : OP_EDGE;
                        t = $urandom;
                        send_req(noise_op, t, 1'b1);
                    end
                    else
                    begin
                        t = t + jitter_period(p, j);
                        send_req(OP_EDGE, t, 1'b1);
                    end
                end
                wide = 64'(p) * 2 + 64'(j) * 2 + 64'd1 + 64'($urandom_range(0, 1000));
                if ($urandom_range(0, 3) == 0)
                    wide = wide + 64'($urandom_range(0, p));
                if (wide > 64'hFFFF_FFFF)
                    t = t + $urandom;
                else
                    t = t + wide[TIME_W-1:0];
                send_req(OP_EDGE, t, 1'b1);
            end
            if (trk_phase == PH_DONE && $urandom_range(0, 1) == 1)
                send_req(OP_EDGE, $urandom, 1'b1);
        end
    endtask

    // receiver: random stall, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (learned_q.size() == 0)
            begin
                bad++;
                if (bad <= MAX_REPORTS)
                    $display("unexpected result: kind %0d value %08h index %0d last %0d",
                             kind, value, entry_index, last);
            end
            else
            begin
                want = learned_q.pop_front();
                if (kind !== want.kind || value !== want.value ||
                    entry_index !== want.entry_index || last !== want.last)
                begin
                    bad++;
                    if (bad <= MAX_REPORTS)
                        $display({"mismatch: exp kind %0d value %08h index %0d last %0d, ",
                                  "got kind %0d value %08h index %0d last %0d"},
                                 want.kind, want.value, want.entry_index, want.last,
                                 kind, value, entry_index, last);
                end
            end
        end
    end

    initial
    begin
        result_t typed_r;
        int      base;
        int      guard;
        bit      hold_done;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        op          <= OP_START;
        edge_time   <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        hold_done = 1'b0;
        lim_cfg   = '0;
        lim_run   = '0;
        clear_tracker();

        dir_tab = '{
            // edges before any start run with a zero limit, times wrap
            '{ROW_REQ, 16'd0,     OP_EDGE,  32'hFFFF_FFF0, 32'd10,        8'd17, 1'b0, KIND_START_OK},
            // finished run ignores edges
            '{ROW_REQ, 16'd0,     OP_EDGE,  32'd5,         32'd3,         8'd2,  1'b0, KIND_START_OK},
            '{ROW_CFG, 16'hFFFF,  OP_START, 32'd0,         32'd0,         8'd0,  1'b0, KIND_START_OK},
            '{ROW_REQ, 16'd0,     OP_START, 32'd0,         32'd0,         8'd1,  1'b1, KIND_START_REJ},
            '{ROW_CFG, 16'd2047,  OP_START, 32'd0,         32'd0,         8'd0,  1'b0, KIND_START_OK},
            '{ROW_REQ, 16'd0,     OP_START, 32'hFFFF_FFFF, 32'd0,         8'd1,  1'b1, KIND_START_REJ},
            '{ROW_CFG, 16'd2046,  OP_START, 32'd0,         32'd0,         8'd0,  1'b0, KIND_START_OK},
            '{ROW_REQ, 16'd0,     OP_START, 32'd0,         32'd0,         8'd1,  1'b1, KIND_START_OK},
            '{ROW_CFG, 16'd4,     OP_START, 32'd0,         32'd0,         8'd0,  1'b0, KIND_START_OK},
            '{ROW_REQ, 16'd0,     OP_START, 32'd0,         32'd0,         8'd1,  1'b1, KIND_START_OK},
            // zero carrier period, then three counted edges
            '{ROW_REQ, 16'd0,     OP_EDGE,  32'd0,         32'd0,         8'd20, 1'b0, KIND_START_OK},
            '{ROW_REQ, 16'd0,     OP_EDGE,  32'd1,         32'd0,         8'd2,  1'b0, KIND_START_OK},
            '{ROW_REQ, 16'd0,     OP_EDGE,  32'd1000,      32'd0,         8'd1,  1'b0, KIND_START_OK},
            '{ROW_REQ, 16'd0,     OP_EDGE,  32'd7,         32'd0,         8'd1,  1'b0, KIND_START_OK},
            '{ROW_REQ, 16'd0,     OP_START, 32'd0,         32'd0,         8'd1,  1'b1, KIND_START_OK},
            // largest period: threshold above 32 bits
            '{ROW_REQ, 16'd0,     OP_EDGE,  32'd0,         32'hFFFF_FFFF, 8'd20, 1'b0, KIND_START_OK},
            '{ROW_CFG, 16'd0,     OP_START, 32'd0,         32'd0,         8'd0,  1'b0, KIND_START_OK},
            '{ROW_REQ, 16'd0,     OP_START, 32'd0,         32'd0,         8'd1,  1'b1, KIND_START_OK},
            '{ROW_REQ, 16'd0,     OP_EDGE,  32'd12345,     32'd40,        8'd17, 1'b0, KIND_START_OK},
            // odd limit ends after the second burst
            '{ROW_CFG, 16'd3,     OP_START, 32'd0,         32'd0,         8'd0,  1'b0, KIND_START_OK},
            '{ROW_REQ, 16'd0,     OP_START, 32'd0,         32'd0,         8'd1,  1'b1, KIND_START_OK},
            '{ROW_REQ, 16'd0,     OP_EDGE,  32'd100,       32'd20,        8'd18, 1'b0, KIND_START_OK},
            '{ROW_REQ, 16'd0,     OP_EDGE,  32'd700,       32'd0,         8'd1,  1'b0, KIND_START_OK},
            '{ROW_REQ, 16'd0,     OP_EDGE,  32'd1000,      32'd0,         8'd1,  1'b0, KIND_START_OK}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idle_mode(3);
        foreach (dir_tab[i])
        begin
            if (dir_tab[i].row_kind == ROW_CFG)
                write_limit(dir_tab[i].limit);
            else
            begin
                for (int k = 0; k < int'(dir_tab[i].reps); k++)
                begin
                    send_req(dir_tab[i].op, dir_tab[i].t0 + TIME_W'(k) * dir_tab[i].step,
                             !dir_tab[i].typed);
                    if (dir_tab[i].typed)
                    begin
                        typed_r      = '0;
                        typed_r.kind = dir_tab[i].typed_kind;
                        learned_q.push_back(typed_r);
                    end
                end
            end
        end

        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS)
        begin
            set_idle_mode(((items_sent - base) / 250) % 4);
            // long receiver hold-off while requests keep coming
            if (!hold_done && items_sent - base >= 1000)
            begin
                hold_done = 1'b1;
                hold_req++;
            end
            learn_session(base + RANDOM_ITEMS);
        end
        in_valid <= 1'b0;

        guard = 0;
        while (learned_q.size() != 0 && guard < 50000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES * 4) @(posedge clk);
        if (bad == 0 && learned_q.size() == 0)
            $display("[ir_pulse_train_learner_unit] OK");
        else
            $display("[ir_pulse_train_learner_unit] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ipl_pkg.sv
rtl/ipl_out_fifo.sv
rtl/ipl_core.sv
rtl/ir_pulse_train_learner_unit.sv
sim/tb_top.sv
